[hw/rtl/wsp_pkg.sv]
// Shared constants, register codes and types for the wheel speed PD controller.
package wsp_pkg;

    // Fixed widths of the register and payload fields
    localparam int DATA_W     = 16;
    localparam int DRV_W      = 8;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = 3;

    // Encoder count and PWM limits
    localparam int COUNT_BITS = 16;
    localparam int PWM_MAX    = 255;

    // Derived datapath widths
    localparam int RAW_W  = COUNT_BITS + DATA_W + 1;
    localparam int ACC_W  = $clog2(PWM_MAX * 256 + 1) + 1;
    localparam int PP_W   = 2 * DATA_W + 1;
    localparam int PD_W   = 2 * DATA_W + 2;
    localparam int TERM_W = 2 * DATA_W + 3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_SETPOINT_LEFT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SETPOINT_RIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P         = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_PER_CNT  = 3'd4;

    // Register reset values
    localparam logic [DATA_W-1:0] RST_SETPOINT_LEFT  = 16'd819;
    localparam logic [DATA_W-1:0] RST_SETPOINT_RIGHT = 16'd0;
    localparam logic [DATA_W-1:0] RST_GAIN_P         = 16'd256;
    localparam logic [DATA_W-1:0] RST_GAIN_D         = 16'd256;
    localparam logic [DATA_W-1:0] RST_SPEED_PER_CNT  = 16'd4001;

    typedef struct packed {
        logic signed [DATA_W-1:0] setpoint_left;
        logic signed [DATA_W-1:0] setpoint_right;
        logic        [DATA_W-1:0] gain_p;
        logic        [DATA_W-1:0] gain_d;
        logic        [DATA_W-1:0] speed_per_count;
    } wsp_cfg_t;

    // Per-stage enables shared by both wheel lanes
    typedef struct packed {
        logic snap;
        logic mul;
        logic spd;
        logic err;
        logic pd;
        logic acc;
    } wsp_step_t;

endpackage

[hw/rtl/wsp_if.sv]
// Valid/ready channel interfaces for encoder samples and control results.
interface wsp_in_if;
    logic valid;
    logic ready;
    logic left_a;
    logic left_b;
    logic right_a;
    logic right_b;
    logic period_end;

    modport source (
        output valid, left_a, left_b, right_a, right_b, period_end,
        input  ready
    );
    modport sink (
        input  valid, left_a, left_b, right_a, right_b, period_end,
        output ready
    );
endinterface

interface wsp_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         drive_left;
    logic               reverse_left;
    logic [7:0]         drive_right;
    logic               reverse_right;
    logic signed [15:0] speed_left;
    logic signed [15:0] speed_right;

    modport source (
        output valid, drive_left, reverse_left, drive_right, reverse_right,
               speed_left, speed_right,
        input  ready
    );
    modport sink (
        input  valid, drive_left, reverse_left, drive_right, reverse_right,
               speed_left, speed_right,
        output ready
    );
endinterface

[hw/rtl/wsp_cfg.sv]
// APB register file holding setpoints, gains and the speed scale.
module wsp_cfg
    import wsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output wsp_cfg_t           cfg
);

    wsp_cfg_t               cfg_reg;
    wsp_cfg_t               cfg_next;
    logic [REG_IDX_W-1:0]   idx;
    logic                   wr_en;
    logic [DATA_W-1:0]      wr_data;

    assign idx     = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign wr_data = pwdata[DATA_W-1:0];
    assign pready  = 1'b1;

    // Decode the write; unknown indexes drop the transfer
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SETPOINT_LEFT:  cfg_next.setpoint_left   = wr_data;
                REG_SETPOINT_RIGHT: cfg_next.setpoint_right  = wr_data;
                REG_GAIN_P:         cfg_next.gain_p          = wr_data;
                REG_GAIN_D:         cfg_next.gain_d          = wr_data;
                REG_SPEED_PER_CNT:  cfg_next.speed_per_count = wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint_left   <= RST_SETPOINT_LEFT;
            cfg_reg.setpoint_right  <= RST_SETPOINT_RIGHT;
            cfg_reg.gain_p          <= RST_GAIN_P;
            cfg_reg.gain_d          <= RST_GAIN_D;
            cfg_reg.speed_per_count <= RST_SPEED_PER_CNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back, zero extended
    always_comb
    begin
        case (idx)
            REG_SETPOINT_LEFT:  prdata = PDATA_W'($unsigned(cfg_reg.setpoint_left));
            REG_SETPOINT_RIGHT: prdata = PDATA_W'($unsigned(cfg_reg.setpoint_right));
            REG_GAIN_P:         prdata = PDATA_W'(cfg_reg.gain_p);
            REG_GAIN_D:         prdata = PDATA_W'(cfg_reg.gain_d);
            REG_SPEED_PER_CNT:  prdata = PDATA_W'(cfg_reg.speed_per_count);
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/wsp_lane.sv]
// One wheel lane: encoder counter, speed scaling and incremental PD accumulator.
module wsp_lane
    import wsp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     count_en,
    input  logic                     enc_b,
    input  logic                     count_up,
    input  wsp_step_t                step,
    input  logic signed [DATA_W-1:0] setpoint,
    input  logic        [DATA_W-1:0] gain_p,
    input  logic        [DATA_W-1:0] gain_d,
    input  logic        [DATA_W-1:0] speed_per_count,
    output logic signed [DATA_W-1:0] speed,
    output logic signed [ACC_W-1:0]  acc
);

    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam logic signed [RAW_W:0]        SPD_HI  = (RAW_W+1)'(32767);
    localparam logic signed [RAW_W:0]        SPD_LO  = -SPD_HI - (RAW_W+1)'(1);
    localparam logic signed [DATA_W:0]       ERR_HI  = (DATA_W+1)'(32767);
    localparam logic signed [DATA_W:0]       ERR_LO  = -ERR_HI - (DATA_W+1)'(1);
    localparam logic signed [TERM_W-1:0]     ACC_HI  = TERM_W'(PWM_MAX * 256);
    localparam logic signed [TERM_W-1:0]     ACC_LO  = -ACC_HI;

    // Control state
    logic                          last_b_reg;
    logic signed [COUNT_BITS-1:0]  count_reg;
    logic signed [COUNT_BITS-1:0]  count_next;
    logic signed [DATA_W-1:0]      prev_err_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;

    // Datapath stages
    logic signed [COUNT_BITS-1:0]  snap_reg;
    logic signed [RAW_W-1:0]       raw_reg;
    logic signed [RAW_W-1:0]       raw_next;
    logic signed [DATA_W-1:0]      speed_reg;
    logic signed [DATA_W-1:0]      speed_next;
    logic signed [DATA_W-1:0]      err_reg;
    logic signed [DATA_W-1:0]      err_next;
    logic signed [PP_W-1:0]        prod_p_reg;
    logic signed [PP_W-1:0]        prod_p_next;
    logic signed [PD_W-1:0]        prod_d_reg;
    logic signed [PD_W-1:0]        prod_d_next;

    logic signed [RAW_W:0]         spd_round;
    logic signed [RAW_W:0]         spd_shift;
    logic signed [DATA_W:0]        err_wide;
    logic signed [DATA_W:0]        err_diff;
    logic signed [TERM_W-1:0]      term;
    logic signed [TERM_W-1:0]      term_step;
    logic signed [TERM_W-1:0]      acc_sum;

    // Count a change of B, saturating at the signed limits
    always_comb
    begin
        count_next = count_reg;
        if (count_en && (enc_b != last_b_reg))
        begin
            if (count_up)
            begin
                if (count_reg != CNT_MAX)
                    count_next = count_reg + COUNT_BITS'(1);
            end
            else
            begin
                if (count_reg != CNT_MIN)
                    count_next = count_reg - COUNT_BITS'(1);
            end
        end
    end

    // Scale the period count to speed
    assign raw_next = RAW_W'(snap_reg) * RAW_W'(signed'({1'b0, speed_per_count}));

    // Round half up, drop 8 fraction bits, saturate
    always_comb
    begin
        spd_round = (RAW_W+1)'(raw_reg) + (RAW_W+1)'(128);
        spd_shift = spd_round >>> 8;
        if (spd_shift > SPD_HI)
            speed_next = DATA_W'(SPD_HI);
        else if (spd_shift < SPD_LO)
            speed_next = DATA_W'(SPD_LO);
        else
            speed_next = DATA_W'(spd_shift);
    end

    // Speed error, saturated
    always_comb
    begin
        err_wide = (DATA_W+1)'(setpoint) - (DATA_W+1)'(speed_reg);
        if (err_wide > ERR_HI)
            err_next = DATA_W'(ERR_HI);
        else if (err_wide < ERR_LO)
            err_next = DATA_W'(ERR_LO);
        else
            err_next = DATA_W'(err_wide);
    end

    // Proportional and derivative products
    assign err_diff    = (DATA_W+1)'(prev_err_reg) - (DATA_W+1)'(err_reg);
    assign prod_p_next = PP_W'(signed'({1'b0, gain_p})) * PP_W'(err_reg);
    assign prod_d_next = PD_W'(signed'({1'b0, gain_d})) * PD_W'(err_diff);

    // Round the PD term to Q.8 and add into the saturating accumulator
    always_comb
    begin
        term      = TERM_W'(prod_p_reg) + TERM_W'(prod_d_reg);
        term_step = (term + TERM_W'(2048)) >>> 12;
        acc_sum   = TERM_W'(acc_reg) + term_step;
        if (acc_sum > ACC_HI)
            acc_next = ACC_W'(ACC_HI);
        else if (acc_sum < ACC_LO)
            acc_next = ACC_W'(ACC_LO);
        else
            acc_next = ACC_W'(acc_sum);
    end

    // Update counter, error history and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_b_reg   <= 1'b0;
            count_reg    <= '0;
            prev_err_reg <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            if (count_en)
            begin
                last_b_reg <= enc_b;
                count_reg  <= step.snap ? '0 : count_next;
            end
            if (step.pd)
                prev_err_reg <= err_reg;
            if (step.acc)
                acc_reg <= acc_next;
        end
    end

    // Advance the datapath stages
    always_ff @(posedge clk)
    begin
        if (step.snap)
            snap_reg <= count_next;
        if (step.mul)
            raw_reg <= raw_next;
        if (step.spd)
            speed_reg <= speed_next;
        if (step.err)
            err_reg <= err_next;
        if (step.pd)
        begin
            prod_p_reg <= prod_p_next;
            prod_d_reg <= prod_d_next;
        end
    end

    assign speed = speed_reg;
    assign acc   = acc_reg;

endmodule

[hw/rtl/wsp_merge.sv]
// Merge both lanes into one result and hold it in the output register.
module wsp_merge
    import wsp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic signed [DATA_W-1:0] speed_l,
    input  logic signed [DATA_W-1:0] speed_r,
    input  logic signed [ACC_W-1:0]  acc_l,
    input  logic signed [ACC_W-1:0]  acc_r,
    output logic                     free,
    wsp_out_if.source                result
);

    logic                     valid_reg;
    logic [DRV_W-1:0]         drive_l_reg;
    logic [DRV_W-1:0]         drive_r_reg;
    logic                     rev_l_reg;
    logic                     rev_r_reg;
    logic signed [DATA_W-1:0] speed_l_reg;
    logic signed [DATA_W-1:0] speed_r_reg;
    logic [ACC_W-1:0]         mag_l;
    logic [ACC_W-1:0]         mag_r;

    // Magnitude of each accumulator
    assign mag_l = acc_l[ACC_W-1] ? ACC_W'(-acc_l) : ACC_W'(acc_l);
    assign mag_r = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

    assign free = !valid_reg || result.ready;

    // Hold the result until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_l_reg <= DRV_W'(mag_l >> 8);
            drive_r_reg <= DRV_W'(mag_r >> 8);
            rev_l_reg   <= (acc_l <= 0);
            rev_r_reg   <= (acc_r <= 0);
            speed_l_reg <= speed_l;
            speed_r_reg <= speed_r;
        end
    end

    assign result.valid         = valid_reg;
    assign result.drive_left    = drive_l_reg;
    assign result.drive_right   = drive_r_reg;
    assign result.reverse_left  = rev_l_reg;
    assign result.reverse_right = rev_r_reg;
    assign result.speed_left    = speed_l_reg;
    assign result.speed_right   = speed_r_reg;

endmodule

[hw/rtl/wheel_speed_pd_control_top.sv]
// Top level of the two-wheel encoder speed PD controller.
//
//   Channel  Direction  Handshake            Contents
//   sample   in         valid/ready          encoder A/B pins of both wheels, period_end
//   result   out        valid/ready          PWM magnitude, direction, speed per wheel
//   APB      in/out     psel/penable/pready  setpoints, gains, speed scale
//
// Samples without period_end are taken every idle cycle; each updates the encoder counters.
// A period_end sample starts an update (multiply, round, error, PD products, accumulate,
// load), run in both wheel lanes side by side; sample.ready is low meanwhile.
// The result is loaded into the output register in the last step; if the previous result is
// still held, the update waits in that step until the output register frees.
// Reset is asynchronous; counters, error history and accumulators clear to zero.
module wheel_speed_pd_control_top
    import wsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    wsp_in_if.sink             sample,
    wsp_out_if.source          result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SPD  = 3'd2;
    localparam logic [2:0] ST_ERR  = 3'd3;
    localparam logic [2:0] ST_PD   = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    wsp_cfg_t                 cfg;
    wsp_step_t                step;
    logic                     accept;
    logic                     out_free;
    logic                     load;
    logic signed [DATA_W-1:0] speed_l;
    logic signed [DATA_W-1:0] speed_r;
    logic signed [ACC_W-1:0]  acc_l;
    logic signed [ACC_W-1:0]  acc_r;

    wsp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign load         = (state_reg == ST_DONE) && out_free;

    // Sequence the update stages
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && sample.period_end) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SPD;
            ST_SPD:  state_next = ST_ERR;
            ST_ERR:  state_next = ST_PD;
            ST_PD:   state_next = ST_ACC;
            ST_ACC:  state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Stage enables for both lanes
    always_comb
    begin
        step.snap = accept && sample.period_end;
        step.mul  = (state_reg == ST_MUL);
        step.spd  = (state_reg == ST_SPD);
        step.err  = (state_reg == ST_ERR);
        step.pd   = (state_reg == ST_PD);
        step.acc  = (state_reg == ST_ACC);
    end

    // Left counts up when A differs from B, right when they match
    wsp_lane u_lane_left (
        .clk             (clk),
        .rst_n           (rst_n),
        .count_en        (accept),
        .enc_b           (sample.left_b),
        .count_up        (sample.left_a ^ sample.left_b),
        .step            (step),
        .setpoint        (cfg.setpoint_left),
        .gain_p          (cfg.gain_p),
        .gain_d          (cfg.gain_d),
        .speed_per_count (cfg.speed_per_count),
        .speed           (speed_l),
        .acc             (acc_l)
    );

    wsp_lane u_lane_right (
        .clk             (clk),
        .rst_n           (rst_n),
        .count_en        (accept),
        .enc_b           (sample.right_b),
        .count_up        (~(sample.right_a ^ sample.right_b)),
        .step            (step),
        .setpoint        (cfg.setpoint_right),
        .gain_p          (cfg.gain_p),
        .gain_d          (cfg.gain_d),
        .speed_per_count (cfg.speed_per_count),
        .speed           (speed_r),
        .acc             (acc_r)
    );

    wsp_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .speed_l (speed_l),
        .speed_r (speed_r),
        .acc_l   (acc_l),
        .acc_r   (acc_r),
        .free    (out_free),
        .result  (result)
    );

endmodule

[hw/rtl/wsp_checker.sv]
// Port-level checks of the controller, bound to the top level.
module wsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        period_end,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] speed_left,
    input logic [7:0]  drive_left
);

    logic pe_xfer;

    assign pe_xfer = in_valid && in_ready && period_end;

    // Stall the sample channel through the update
    a_busy_after_period: assert property (@(posedge clk) disable iff (!rst_n)
        pe_xfer |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("sample accepted during control update");

    // A fresh result only follows a period-end transfer
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(pe_xfer, 7))
        else $error("result without matching period-end transfer");

    // A result is never produced while the sample channel is open and idle
    a_no_result_from_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !period_end && !out_valid) |=> !out_valid)
        else $error("result after a sample without period end");

    // Hold a stalled result
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(speed_left)
                                       && $stable(drive_left)))
        else $error("stalled result changed");

endmodule

bind wheel_speed_pd_control_top wsp_checker u_wsp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .period_end (sample.period_end),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .speed_left (result.speed_left),
    .drive_left (result.drive_left)
);
